### design/bccc_pkg.sv
// bccc_pkg: widths, codes, constants, item types and helper functions for the
// battery charge current controller
// no dependencies
package bccc_pkg;

   // field widths
   localparam int MV_W       = 14;
   localparam int MA_W       = 18;
   localparam int SOC_W      = 11;
   localparam int PCT_W      = 7;
   localparam int NOTE_W     = 2;
   localparam int TIME_W     = 32;
   localparam int SUM_W      = 16;
   localparam int CNT_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   // item kinds
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_STEP   = 1'b1;

   // note codes
   localparam logic [NOTE_W-1:0] NOTE_NONE      = 2'd0;
   localparam logic [NOTE_W-1:0] NOTE_FULL      = 2'd1;
   localparam logic [NOTE_W-1:0] NOTE_HARD_STOP = 2'd2;

   // register map
   localparam logic [CSR_IDX_W-1:0] REG_LOW_CELL_BLOCK   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_CELL_RELEASE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CELL_FULL        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CHARGE_RESUME    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RAMP_DOWN        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HARD_STOP        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CHARGE_LIMIT     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_DISCHARGE_LIMIT  = 3'd7;

   // register reset values
   localparam logic [MV_W-1:0] LOW_CELL_BLOCK_RST   = 14'd2900;
   localparam logic [MV_W-1:0] LOW_CELL_RELEASE_RST = 14'd3100;
   localparam logic [MV_W-1:0] CELL_FULL_RST        = 14'd3460;
   localparam logic [MV_W-1:0] CHARGE_RESUME_RST    = 14'd3350;
   localparam logic [MV_W-1:0] RAMP_DOWN_RST        = 14'd3420;
   localparam logic [MV_W-1:0] HARD_STOP_RST        = 14'd3480;
   localparam logic [MA_W-1:0] CHARGE_LIMIT_RST     = 18'd100000;
   localparam logic [MA_W-1:0] DISCHARGE_LIMIT_RST  = 18'd100000;

   // fixed control constants
   localparam logic [MV_W-1:0]   RAMP_CAP_MV      = 14'd3400;
   localparam logic [MV_W-1:0]   HOLD_RELEASE_MV  = 14'd3350;
   localparam logic [TIME_W-1:0] RAMP_PERIOD_MS   = 32'd10000;
   localparam int                HOLD_SECONDS     = 60;
   localparam logic [TIME_W-1:0] HOLD_MS          = TIME_W'(HOLD_SECONDS * 1000);
   localparam logic [MA_W-1:0]   START_CURRENT_MA = 18'd5000;

   // state of charge thresholds, per mille
   localparam logic [SOC_W-1:0] SOC_FULL_PM   = 11'd1000;
   localparam logic [SOC_W-1:0] SOC_RESUME_PM = 11'd980;
   localparam logic [SOC_W-1:0] SOC_EMPTY_PM  = 11'd100;
   localparam logic [SOC_W-1:0] SOC_TAPER1_PM = 11'd950;
   localparam logic [SOC_W-1:0] SOC_TAPER2_PM = 11'd990;
   localparam logic [SOC_W-1:0] SOC_TAPER3_PM = 11'd995;

   localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
   localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd10;

   // current levels
   localparam logic [MA_W-1:0] MA_TAPER1    = 18'd50000;
   localparam logic [MA_W-1:0] MA_TAPER2    = 18'd20000;
   localparam logic [MA_W-1:0] MA_TAPER3    = 18'd5000;
   localparam logic [MA_W-1:0] MA_STEP_DOWN = 18'd1000;
   localparam logic [MA_W-1:0] MA_INC_SMALL = 18'd1000;
   localparam logic [MA_W-1:0] MA_INC_MID   = 18'd2000;
   localparam logic [MA_W-1:0] MA_INC_LARGE = 18'd3000;
   localparam logic [MA_W-1:0] MA_SMALL_MAX = 18'd30000;

   // divide by three: floor(x * ceil(2^17 / 3) / 2^17), exact for x < 2^17
   localparam int               RECIP3_SHIFT = 17;
   localparam logic [16:0]      RECIP3       = 17'd43691;

   typedef struct packed {
      logic              action;
      logic [MV_W-1:0]   sample_min_mv;
      logic [MV_W-1:0]   sample_max_mv;
      logic [SOC_W-1:0]  charge_level_pm;
      logic              charge_switch_on;
      logic              discharge_switch_on;
      logic              is_charging;
      logic [TIME_W-1:0] now_ms;
   } req_item_type;

   typedef struct packed {
      logic [MA_W-1:0]   charge_current_ma;
      logic [MA_W-1:0]   discharge_current_ma;
      logic              full_block;
      logic              empty_block;
      logic              ramp_blocked;
      logic [SOC_W-1:0]  corrected_level_pm;
      logic              recalibrate;
      logic [PCT_W-1:0]  recalibrate_percent;
      logic [NOTE_W-1:0] note_code;
      logic [MV_W-1:0]   avg_min_mv;
      logic [MV_W-1:0]   avg_max_mv;
   } rsp_item_type;

   // current write: nonzero ignored with switch open, saturate at the limit
   function automatic logic [MA_W-1:0] current_write(input logic sw,
                                                     input logic [MA_W-1:0] cur,
                                                     input logic [MA_W:0] ma,
                                                     input logic [MA_W-1:0] lim);
      logic [MA_W-1:0] res;
      if (ma != '0 && !sw) begin
         res = cur;
      end else if (ma > {1'b0, lim}) begin
         res = lim;
      end else begin
         res = ma[MA_W-1:0];
      end
      return res;
   endfunction

   // block average of a three-sample sum, kept to 14 bits
   function automatic logic [MV_W-1:0] div3(input logic [SUM_W-1:0] sum);
      logic [SUM_W+16:0] prod;
      prod = sum * RECIP3;
      return prod[RECIP3_SHIFT +: MV_W];
   endfunction

endpackage

### design/battery_charge_current_controller_top.sv
// battery_charge_current_controller_top: sample averaging and charge/discharge
// current limiting in one registered pass
// depends on bccc_pkg
//
// One item per clock cycle while the result side is not stalled. An accepted
// word sits in the input register while a single compare-and-select pass
// evaluates it against the controller state; the result word and the updated
// state are written at the same edge, so the next item sees this item's state
// with no bubble. An accepted word passes the input register and then the
// result register, from which the result word is offered. The result register
// decouples the two sides: a new word is taken while a finished one still
// waits, and req_stall rises only when both the input register and the result
// register are full and rsp_stall is high.
// A sample word (action 0) builds a three-sample block average of the lowest
// and highest cell voltages; the divide by three is a constant reciprocal
// multiply. A step word (action 1) runs the control rules: low-voltage
// discharge block, full block, state-of-charge recalibration, taper caps,
// timed ramp of the charge current with a hold and release delay, restart
// current and hard stop. Time differences wrap modulo 2^32. The csr port is
// always ready; registers are to be written only while no word is in flight.
module battery_charge_current_controller_top (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic [bccc_pkg::MV_W-1:0]          req_sample_min_mv,
   input  logic [bccc_pkg::MV_W-1:0]          req_sample_max_mv,
   input  logic [bccc_pkg::SOC_W-1:0]         req_charge_level_pm,
   input  logic                               req_charge_switch_on,
   input  logic                               req_discharge_switch_on,
   input  logic                               req_is_charging,
   input  logic [bccc_pkg::TIME_W-1:0]        req_now_ms,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bccc_pkg::MA_W-1:0]          rsp_charge_current_ma,
   output logic [bccc_pkg::MA_W-1:0]          rsp_discharge_current_ma,
   output logic                               rsp_full_block,
   output logic                               rsp_empty_block,
   output logic                               rsp_ramp_blocked,
   output logic [bccc_pkg::SOC_W-1:0]         rsp_corrected_level_pm,
   output logic                               rsp_recalibrate,
   output logic [bccc_pkg::PCT_W-1:0]         rsp_recalibrate_percent,
   output logic [bccc_pkg::NOTE_W-1:0]        rsp_note_code,
   output logic [bccc_pkg::MV_W-1:0]          rsp_avg_min_mv,
   output logic [bccc_pkg::MV_W-1:0]          rsp_avg_max_mv,
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bccc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bccc_pkg::CSR_DATA_W-1:0]    csr_data
);

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [bccc_pkg::MV_W-1:0] low_cell_block_ff;
   logic [bccc_pkg::MV_W-1:0] low_cell_release_ff;
   logic [bccc_pkg::MV_W-1:0] cell_full_ff;
   logic [bccc_pkg::MV_W-1:0] charge_resume_ff;
   logic [bccc_pkg::MV_W-1:0] ramp_down_ff;
   logic [bccc_pkg::MV_W-1:0] hard_stop_ff;
   logic [bccc_pkg::MA_W-1:0] charge_limit_ff;
   logic [bccc_pkg::MA_W-1:0] discharge_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_cell_block_ff   <= bccc_pkg::LOW_CELL_BLOCK_RST;
         low_cell_release_ff <= bccc_pkg::LOW_CELL_RELEASE_RST;
         cell_full_ff        <= bccc_pkg::CELL_FULL_RST;
         charge_resume_ff    <= bccc_pkg::CHARGE_RESUME_RST;
         ramp_down_ff        <= bccc_pkg::RAMP_DOWN_RST;
         hard_stop_ff        <= bccc_pkg::HARD_STOP_RST;
         charge_limit_ff     <= bccc_pkg::CHARGE_LIMIT_RST;
         discharge_limit_ff  <= bccc_pkg::DISCHARGE_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bccc_pkg::REG_LOW_CELL_BLOCK:   low_cell_block_ff   <= csr_data[bccc_pkg::MV_W-1:0];
            bccc_pkg::REG_LOW_CELL_RELEASE: low_cell_release_ff <= csr_data[bccc_pkg::MV_W-1:0];
            bccc_pkg::REG_CELL_FULL:        cell_full_ff        <= csr_data[bccc_pkg::MV_W-1:0];
            bccc_pkg::REG_CHARGE_RESUME:    charge_resume_ff    <= csr_data[bccc_pkg::MV_W-1:0];
            bccc_pkg::REG_RAMP_DOWN:        ramp_down_ff        <= csr_data[bccc_pkg::MV_W-1:0];
            bccc_pkg::REG_HARD_STOP:        hard_stop_ff        <= csr_data[bccc_pkg::MV_W-1:0];
            bccc_pkg::REG_CHARGE_LIMIT:     charge_limit_ff     <= csr_data[bccc_pkg::MA_W-1:0];
            bccc_pkg::REG_DISCHARGE_LIMIT:  discharge_limit_ff  <= csr_data[bccc_pkg::MA_W-1:0];
         endcase
      end
   end

   // ---------------------------------------------------------------
   // handshake: input register, result register
   // ---------------------------------------------------------------
   logic                   in_valid_ff;
   logic                   in_valid_in;
   bccc_pkg::req_item_type in_item_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   bccc_pkg::rsp_item_type rsp_item_ff;
   bccc_pkg::rsp_item_type rsp_item_in;
   logic                   out_free;
   logic                   req_accept;
   logic                   work;

   // result slot can take a word this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // input register holds its word only while the result slot is blocked
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;
   // the word in the input register is evaluated and retired this cycle
   assign work       = in_valid_ff && out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.action              <= req_action;
         in_item_ff.sample_min_mv       <= req_sample_min_mv;
         in_item_ff.sample_max_mv       <= req_sample_max_mv;
         in_item_ff.charge_level_pm     <= req_charge_level_pm;
         in_item_ff.charge_switch_on    <= req_charge_switch_on;
         in_item_ff.discharge_switch_on <= req_discharge_switch_on;
         in_item_ff.is_charging         <= req_is_charging;
         in_item_ff.now_ms              <= req_now_ms;
      end
      if (work) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // ---------------------------------------------------------------
   // controller state
   // ---------------------------------------------------------------
   logic [bccc_pkg::SUM_W-1:0]  min_sum_ff,           min_sum_in;
   logic [bccc_pkg::SUM_W-1:0]  max_sum_ff,           max_sum_in;
   logic [bccc_pkg::CNT_W-1:0]  sample_count_ff,      sample_count_in;
   logic [bccc_pkg::MV_W-1:0]   min_average_ff,       min_average_in;
   logic [bccc_pkg::MV_W-1:0]   max_average_ff,       max_average_in;
   logic                        low_block_ff,         low_block_in;
   logic                        full_block_ff,        full_block_in;
   logic                        hold_ff,              hold_in;
   logic                        hold_from_level_ff,   hold_from_level_in;
   logic [bccc_pkg::TIME_W-1:0] last_ramp_time_ff,    last_ramp_time_in;
   logic [bccc_pkg::TIME_W-1:0] last_high_time_ff,    last_high_time_in;
   logic [bccc_pkg::MA_W-1:0]   charge_setting_ff,    charge_setting_in;
   logic [bccc_pkg::MA_W-1:0]   discharge_setting_ff, discharge_setting_in;

   // wrapping time since the last ramp step and the last high-voltage sighting
   logic [bccc_pkg::TIME_W-1:0] ramp_age;
   logic [bccc_pkg::TIME_W-1:0] high_age;

   assign ramp_age = in_item_ff.now_ms - last_ramp_time_ff;
   assign high_age = in_item_ff.now_ms - last_high_time_ff;

   // working values of the single pass
   logic [bccc_pkg::SOC_W-1:0]  soc;
   logic                        recal;
   logic [bccc_pkg::PCT_W-1:0]  pct;
   logic [bccc_pkg::NOTE_W-1:0] note;
   logic [bccc_pkg::MA_W-1:0]   inc;
   logic                        csw;

   always_comb begin
      min_sum_in           = min_sum_ff;
      max_sum_in           = max_sum_ff;
      sample_count_in      = sample_count_ff;
      min_average_in       = min_average_ff;
      max_average_in       = max_average_ff;
      low_block_in         = low_block_ff;
      full_block_in        = full_block_ff;
      hold_in              = hold_ff;
      hold_from_level_in   = hold_from_level_ff;
      last_ramp_time_in    = last_ramp_time_ff;
      last_high_time_in    = last_high_time_ff;
      charge_setting_in    = charge_setting_ff;
      discharge_setting_in = discharge_setting_ff;
      soc                  = in_item_ff.charge_level_pm;
      recal                = 1'b0;
      pct                  = '0;
      note                 = bccc_pkg::NOTE_NONE;
      inc                  = bccc_pkg::MA_INC_SMALL;
      csw                  = in_item_ff.charge_switch_on;

      if (in_item_ff.action == bccc_pkg::ACT_SAMPLE) begin
         // three-sample block average, restart after the third
         if (sample_count_ff != 2'd3) begin
            sample_count_in = sample_count_ff + 2'd1;
            min_sum_in      = min_sum_ff + bccc_pkg::SUM_W'(in_item_ff.sample_min_mv);
            max_sum_in      = max_sum_ff + bccc_pkg::SUM_W'(in_item_ff.sample_max_mv);
         end else begin
            sample_count_in = 2'd1;
            min_sum_in      = bccc_pkg::SUM_W'(in_item_ff.sample_min_mv);
            max_sum_in      = bccc_pkg::SUM_W'(in_item_ff.sample_max_mv);
         end
         if (sample_count_in == 2'd3) begin
            min_average_in = bccc_pkg::div3(min_sum_in);
            max_average_in = bccc_pkg::div3(max_sum_in);
         end
         // no average yet: follow the live sample
         if (min_average_in == '0) begin
            min_average_in = in_item_ff.sample_min_mv;
         end
         if (max_average_in == '0) begin
            max_average_in = in_item_ff.sample_max_mv;
         end
      end else begin
         // discharge side
         if (min_average_ff < low_cell_block_ff) begin
            low_block_in = 1'b1;
            if (soc > bccc_pkg::SOC_EMPTY_PM) begin
               soc   = bccc_pkg::SOC_EMPTY_PM;
               recal = 1'b1;
               pct   = bccc_pkg::PCT_EMPTY;
            end
         end
         if (min_average_ff > low_cell_release_ff) begin
            low_block_in = 1'b0;
         end
         if (!low_block_in) begin
            discharge_setting_in = bccc_pkg::current_write(in_item_ff.discharge_switch_on,
               discharge_setting_ff, {1'b0, discharge_limit_ff}, discharge_limit_ff);
         end

         // full block with hysteresis
         if (max_average_ff > cell_full_ff || soc > bccc_pkg::SOC_FULL_PM) begin
            full_block_in = 1'b1;
            soc           = bccc_pkg::SOC_FULL_PM;
            recal         = 1'b1;
            pct           = bccc_pkg::PCT_FULL;
         end
         if (max_average_ff < charge_resume_ff || soc < bccc_pkg::SOC_RESUME_PM) begin
            full_block_in = 1'b0;
         end

         if (full_block_in) begin
            charge_setting_in = '0;
            note              = bccc_pkg::NOTE_FULL;
         end else if (in_item_ff.is_charging) begin
            // taper caps by state of charge
            if (soc > bccc_pkg::SOC_TAPER1_PM && charge_setting_in > bccc_pkg::MA_TAPER1) begin
               charge_setting_in  = bccc_pkg::current_write(csw, charge_setting_in,
                  {1'b0, bccc_pkg::MA_TAPER1}, charge_limit_ff);
               hold_in            = 1'b1;
               hold_from_level_in = 1'b1;
            end
            if (soc > bccc_pkg::SOC_TAPER2_PM && charge_setting_in > bccc_pkg::MA_TAPER2) begin
               charge_setting_in  = bccc_pkg::current_write(csw, charge_setting_in,
                  {1'b0, bccc_pkg::MA_TAPER2}, charge_limit_ff);
               hold_in            = 1'b1;
               hold_from_level_in = 1'b1;
            end
            if (soc > bccc_pkg::SOC_TAPER3_PM && charge_setting_in > bccc_pkg::MA_TAPER3) begin
               charge_setting_in  = bccc_pkg::current_write(csw, charge_setting_in,
                  {1'b0, bccc_pkg::MA_TAPER3}, charge_limit_ff);
               hold_in            = 1'b1;
               hold_from_level_in = 1'b1;
            end

            // timed ramp
            if (ramp_age > bccc_pkg::RAMP_PERIOD_MS) begin
               last_ramp_time_in = in_item_ff.now_ms;
               if (max_average_ff > bccc_pkg::RAMP_CAP_MV
                   && charge_setting_in > bccc_pkg::MA_TAPER2) begin
                  charge_setting_in = bccc_pkg::current_write(csw, charge_setting_in,
                     {1'b0, bccc_pkg::MA_TAPER2}, charge_limit_ff);
                  hold_in           = 1'b1;
               end
               if (max_average_ff > ramp_down_ff) begin
                  hold_in = 1'b1;
                  if (charge_setting_in > bccc_pkg::MA_TAPER3) begin
                     charge_setting_in = bccc_pkg::current_write(csw, charge_setting_in,
                        {1'b0, charge_setting_in - bccc_pkg::MA_STEP_DOWN}, charge_limit_ff);
                  end
               end
               if (charge_setting_in < charge_limit_ff && !hold_in && csw
                   && in_item_ff.discharge_switch_on) begin
                  // larger steps at higher currents
                  priority if (charge_setting_in <= bccc_pkg::MA_SMALL_MAX) begin
                     inc = bccc_pkg::MA_INC_SMALL;
                  end else if (charge_setting_in <= bccc_pkg::MA_TAPER1) begin
                     inc = bccc_pkg::MA_INC_MID;
                  end else begin
                     inc = bccc_pkg::MA_INC_LARGE;
                  end
                  charge_setting_in = bccc_pkg::current_write(csw, charge_setting_in,
                     {1'b0, charge_setting_in} + {1'b0, inc}, charge_limit_ff);
               end
            end

            // hold release after the pack stays below the release level
            if (max_average_ff < bccc_pkg::HOLD_RELEASE_MV) begin
               if (hold_in && high_age > bccc_pkg::HOLD_MS && !hold_from_level_in) begin
                  hold_in = 1'b0;
               end
            end else begin
               last_high_time_in  = in_item_ff.now_ms;
               hold_from_level_in = 1'b0;
            end
         end

         // restart current after a full charge
         if (charge_setting_in == '0 && max_average_ff < charge_resume_ff && !full_block_in) begin
            charge_setting_in = bccc_pkg::current_write(csw, charge_setting_in,
               {1'b0, bccc_pkg::START_CURRENT_MA}, charge_limit_ff);
         end

         // hard stop overrides the charge current and the note code
         if (max_average_ff > hard_stop_ff) begin
            charge_setting_in = '0;
            note              = bccc_pkg::NOTE_HARD_STOP;
         end
      end

      rsp_item_in.charge_current_ma    = charge_setting_in;
      rsp_item_in.discharge_current_ma = discharge_setting_in;
      rsp_item_in.full_block           = full_block_in;
      rsp_item_in.empty_block          = low_block_in;
      rsp_item_in.ramp_blocked         = hold_in;
      rsp_item_in.corrected_level_pm   = soc;
      rsp_item_in.recalibrate          = recal;
      rsp_item_in.recalibrate_percent  = pct;
      rsp_item_in.note_code            = note;
      rsp_item_in.avg_min_mv           = min_average_in;
      rsp_item_in.avg_max_mv           = max_average_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_sum_ff           <= '0;
         max_sum_ff           <= '0;
         sample_count_ff      <= '0;
         min_average_ff       <= '0;
         max_average_ff       <= '0;
         low_block_ff         <= 1'b0;
         full_block_ff        <= 1'b0;
         hold_ff              <= 1'b0;
         hold_from_level_ff   <= 1'b0;
         last_ramp_time_ff    <= '0;
         last_high_time_ff    <= '0;
         charge_setting_ff    <= '0;
         discharge_setting_ff <= '0;
      end else if (work) begin
         min_sum_ff           <= min_sum_in;
         max_sum_ff           <= max_sum_in;
         sample_count_ff      <= sample_count_in;
         min_average_ff       <= min_average_in;
         max_average_ff       <= max_average_in;
         low_block_ff         <= low_block_in;
         full_block_ff        <= full_block_in;
         hold_ff              <= hold_in;
         hold_from_level_ff   <= hold_from_level_in;
         last_ramp_time_ff    <= last_ramp_time_in;
         last_high_time_ff    <= last_high_time_in;
         charge_setting_ff    <= charge_setting_in;
         discharge_setting_ff <= discharge_setting_in;
      end
   end

   // ---------------------------------------------------------------
   // result ports
   // ---------------------------------------------------------------
   assign rsp_valid                = rsp_valid_ff;
   assign rsp_charge_current_ma    = rsp_item_ff.charge_current_ma;
   assign rsp_discharge_current_ma = rsp_item_ff.discharge_current_ma;
   assign rsp_full_block           = rsp_item_ff.full_block;
   assign rsp_empty_block          = rsp_item_ff.empty_block;
   assign rsp_ramp_blocked         = rsp_item_ff.ramp_blocked;
   assign rsp_corrected_level_pm   = rsp_item_ff.corrected_level_pm;
   assign rsp_recalibrate          = rsp_item_ff.recalibrate;
   assign rsp_recalibrate_percent  = rsp_item_ff.recalibrate_percent;
   assign rsp_note_code            = rsp_item_ff.note_code;
   assign rsp_avg_min_mv           = rsp_item_ff.avg_min_mv;
   assign rsp_avg_max_mv           = rsp_item_ff.avg_max_mv;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
`ifndef ASSERT_OFF
   // hard stop always leaves zero charge current
   a_hard_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.note_code == bccc_pkg::NOTE_HARD_STOP
      |-> rsp_item_ff.charge_current_ma == '0)
      else $error("hard stop with nonzero charge current");

   // an active full block never coexists with charge current
   a_full_block_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.full_block |-> rsp_item_ff.charge_current_ma == '0)
      else $error("full block with nonzero charge current");

   // a percent is reported only with a recalibration
   a_pct_needs_recal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.recalibrate |-> rsp_item_ff.recalibrate_percent == '0)
      else $error("recalibration percent without recalibration");

   // a stalled result word keeps the input word waiting in place
   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> in_valid_ff && $stable(in_item_ff))
      else $error("input word lost while stalled");
`endif

endmodule

### dv/charge_limit_check_pkg.sv
// charge_limit_check_pkg: scoreboard for the battery charge current controller,
// with its own predictor of the limits and a queue of expected result words
// depends on bccc_pkg
package charge_limit_check_pkg;
   import bccc_pkg::*;

   class charge_limit_scoreboard;
      // register copies
      bit [MV_W-1:0]   low_block_mv, low_release_mv, full_mv, resume_mv;
      bit [MV_W-1:0]   step_down_mv, stop_mv;
      bit [MA_W-1:0]   charge_lim, discharge_lim;
      // controller state
      bit [SUM_W-1:0]  min_acc, max_acc;
      bit [CNT_W-1:0]  n_samples;
      bit [MV_W-1:0]   min_avg, max_avg;
      bit              low_blk, full_blk, hold_active, hold_by_level;
      bit [TIME_W-1:0] last_ramp_ms, last_high_ms;
      bit [MA_W-1:0]   chg_setting, dis_setting;
      rsp_item_type    expected_words[$];
      int              mismatches;

      function new();
         low_block_mv   = LOW_CELL_BLOCK_RST;
         low_release_mv = LOW_CELL_RELEASE_RST;
         full_mv        = CELL_FULL_RST;
         resume_mv      = CHARGE_RESUME_RST;
         step_down_mv   = RAMP_DOWN_RST;
         stop_mv        = HARD_STOP_RST;
         charge_lim     = CHARGE_LIMIT_RST;
         discharge_lim  = DISCHARGE_LIMIT_RST;
         mismatches     = 0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_LOW_CELL_BLOCK:   low_block_mv   = data[MV_W-1:0];
            REG_LOW_CELL_RELEASE: low_release_mv = data[MV_W-1:0];
            REG_CELL_FULL:        full_mv        = data[MV_W-1:0];
            REG_CHARGE_RESUME:    resume_mv      = data[MV_W-1:0];
            REG_RAMP_DOWN:        step_down_mv   = data[MV_W-1:0];
            REG_HARD_STOP:        stop_mv        = data[MV_W-1:0];
            REG_CHARGE_LIMIT:     charge_lim     = data[MA_W-1:0];
            REG_DISCHARGE_LIMIT:  discharge_lim  = data[MA_W-1:0];
            default: ;
         endcase
      endfunction

      // nonzero write ignored with the switch open, saturated at the limit
      function void write_chg(bit sw, bit [MA_W:0] ma);
         if (ma != '0 && !sw) return;
         if (ma > {1'b0, charge_lim}) chg_setting = charge_lim;
         else chg_setting = ma[MA_W-1:0];
      endfunction

      function void write_dis(bit sw, bit [MA_W:0] ma);
         if (ma != '0 && !sw) return;
         if (ma > {1'b0, discharge_lim}) dis_setting = discharge_lim;
         else dis_setting = ma[MA_W-1:0];
      endfunction

      function void note_request(req_item_type w);
         bit [SOC_W-1:0]  level;
         bit [PCT_W-1:0]  pct;
         bit [MA_W-1:0]   inc;
         bit              recal, csw, dsw;
         bit [NOTE_W-1:0] note;
         bit [TIME_W-1:0] since_ramp, since_high;
         rsp_item_type    want;
         level = w.charge_level_pm;
         pct   = '0;
         recal = 1'b0;
         note  = NOTE_NONE;
         csw   = w.charge_switch_on;
         dsw   = w.discharge_switch_on;
         if (w.action == ACT_SAMPLE) begin
            if (n_samples < 2'd3) begin
               n_samples++;
               min_acc = min_acc + SUM_W'(w.sample_min_mv);
               max_acc = max_acc + SUM_W'(w.sample_max_mv);
            end else begin
               n_samples = 2'd1;
               min_acc   = SUM_W'(w.sample_min_mv);
               max_acc   = SUM_W'(w.sample_max_mv);
            end
            if (n_samples == 2'd3) begin
               min_avg = MV_W'(min_acc / SUM_W'(3));
               max_avg = MV_W'(max_acc / SUM_W'(3));
            end
            // no average yet: instantaneous value stands in
            if (min_avg == '0) min_avg = w.sample_min_mv;
            if (max_avg == '0) max_avg = w.sample_max_mv;
         end else begin
            since_ramp = w.now_ms - last_ramp_ms;
            since_high = w.now_ms - last_high_ms;
            // discharge side
            if (min_avg < low_block_mv) begin
               low_blk = 1'b1;
               if (level > SOC_EMPTY_PM) begin
                  level = SOC_EMPTY_PM;
                  recal = 1'b1;
                  pct   = PCT_EMPTY;
               end
            end
            if (min_avg > low_release_mv) low_blk = 1'b0;
            if (!low_blk) write_dis(dsw, {1'b0, discharge_lim});
            // charge side
            if (max_avg > full_mv || level > SOC_FULL_PM) begin
               full_blk = 1'b1;
               level    = SOC_FULL_PM;
               recal    = 1'b1;
               pct      = PCT_FULL;
            end
            if (max_avg < resume_mv || level < SOC_RESUME_PM) full_blk = 1'b0;
            if (full_blk) begin
               write_chg(csw, '0);
               note = NOTE_FULL;
            end else if (w.is_charging) begin
               if (level > SOC_TAPER1_PM && chg_setting > MA_TAPER1) begin
                  write_chg(csw, {1'b0, MA_TAPER1});
                  hold_active   = 1'b1;
                  hold_by_level = 1'b1;
               end
               if (level > SOC_TAPER2_PM && chg_setting > MA_TAPER2) begin
                  write_chg(csw, {1'b0, MA_TAPER2});
                  hold_active   = 1'b1;
                  hold_by_level = 1'b1;
               end
               if (level > SOC_TAPER3_PM && chg_setting > MA_TAPER3) begin
                  write_chg(csw, {1'b0, MA_TAPER3});
                  hold_active   = 1'b1;
                  hold_by_level = 1'b1;
               end
               if (since_ramp > RAMP_PERIOD_MS) begin
                  last_ramp_ms = w.now_ms;
                  if (max_avg > RAMP_CAP_MV && chg_setting > MA_TAPER2) begin
                     write_chg(csw, {1'b0, MA_TAPER2});
                     hold_active = 1'b1;
                  end
                  if (max_avg > step_down_mv) begin
                     hold_active = 1'b1;
                     if (chg_setting > MA_TAPER3)
                        write_chg(csw, {1'b0, chg_setting - MA_STEP_DOWN});
                  end
                  if (chg_setting < charge_lim && !hold_active && csw && dsw) begin
                     inc = (chg_setting <= MA_SMALL_MAX) ? MA_INC_SMALL :
                           (chg_setting <= MA_TAPER1)    ? MA_INC_MID : MA_INC_LARGE;
                     write_chg(csw, {1'b0, chg_setting} + {1'b0, inc});
                  end
               end
               if (max_avg < HOLD_RELEASE_MV) begin
                  if (hold_active && since_high > HOLD_MS && !hold_by_level)
                     hold_active = 1'b0;
               end else begin
                  last_high_ms  = w.now_ms;
                  hold_by_level = 1'b0;
               end
            end
            if (chg_setting == '0 && max_avg < resume_mv && !full_blk)
               write_chg(csw, {1'b0, START_CURRENT_MA});
            if (max_avg > stop_mv) begin
               write_chg(csw, '0);
               note = NOTE_HARD_STOP;
            end
         end
         want.charge_current_ma    = chg_setting;
         want.discharge_current_ma = dis_setting;
         want.full_block           = full_blk;
         want.empty_block          = low_blk;
         want.ramp_blocked         = hold_active;
         want.corrected_level_pm   = level;
         want.recalibrate          = recal;
         want.recalibrate_percent  = pct;
         want.note_code            = note;
         want.avg_min_mv           = min_avg;
         want.avg_max_mv           = max_avg;
         expected_words.push_back(want);
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", what);
      endfunction

      function void compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) flag($sformatf("%s expected %0d got %0d", name, want, got));
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type want;
         if (expected_words.size() == 0) begin
            flag("result word with nothing expected");
            return;
         end
         want = expected_words.pop_front();
         compare_field("charge_current_ma", 32'(got.charge_current_ma),
                       32'(want.charge_current_ma));
         compare_field("discharge_current_ma", 32'(got.discharge_current_ma),
                       32'(want.discharge_current_ma));
         compare_field("full_block", 32'(got.full_block), 32'(want.full_block));
         compare_field("empty_block", 32'(got.empty_block), 32'(want.empty_block));
         compare_field("ramp_blocked", 32'(got.ramp_blocked), 32'(want.ramp_blocked));
         compare_field("corrected_level_pm", 32'(got.corrected_level_pm),
                       32'(want.corrected_level_pm));
         compare_field("recalibrate", 32'(got.recalibrate), 32'(want.recalibrate));
         compare_field("recalibrate_percent", 32'(got.recalibrate_percent),
                       32'(want.recalibrate_percent));
         compare_field("note_code", 32'(got.note_code), 32'(want.note_code));
         compare_field("avg_min_mv", 32'(got.avg_min_mv), 32'(want.avg_min_mv));
         compare_field("avg_max_mv", 32'(got.avg_max_mv), 32'(want.avg_max_mv));
      endfunction
   endclass

endpackage

### dv/battery_charge_current_controller_top_tb.sv
// battery_charge_current_controller_top_tb: drives sample and step words with random
// idling on both sides across several register settings and checks every result word
// depends on bccc_pkg, charge_limit_check_pkg and the controller rtl
module battery_charge_current_controller_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bccc_pkg::*;
   import charge_limit_check_pkg::*;

   // generous bound, far above the slowest correct run
   localparam int CYCLE_LIMIT = 200000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   // request channel
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_action = ACT_SAMPLE;
   logic [MV_W-1:0]       req_sample_min_mv = '0;
   logic [MV_W-1:0]       req_sample_max_mv = '0;
   logic [SOC_W-1:0]      req_charge_level_pm = '0;
   logic                  req_charge_switch_on = 1'b0;
   logic                  req_discharge_switch_on = 1'b0;
   logic                  req_is_charging = 1'b0;
   logic [TIME_W-1:0]     req_now_ms = '0;
   // response channel
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [MA_W-1:0]       rsp_charge_current_ma;
   logic [MA_W-1:0]       rsp_discharge_current_ma;
   logic                  rsp_full_block;
   logic                  rsp_empty_block;
   logic                  rsp_ramp_blocked;
   logic [SOC_W-1:0]      rsp_corrected_level_pm;
   logic                  rsp_recalibrate;
   logic [PCT_W-1:0]      rsp_recalibrate_percent;
   logic [NOTE_W-1:0]     rsp_note_code;
   logic [MV_W-1:0]       rsp_avg_min_mv;
   logic [MV_W-1:0]       rsp_avg_max_mv;
   // register writes
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = REG_LOW_CELL_BLOCK;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   charge_limit_scoreboard sb;
   bit                     quiet_stretch = 1'b0;  // no idling on either side
   bit [TIME_W-1:0]        clock_ms;              // simulated wall time in ms
   int unsigned            cycles = 0;

   battery_charge_current_controller_top dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: stalls at random, with a chance of 7 in 100, outside the quiet stretch
   always @(posedge clock) begin
      rsp_stall <= !quiet_stretch && ($urandom_range(99, 0) < 7);
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("** battery_charge_current_controller_top: FAILED **");
         $finish;
      end
   end

   // sample all three channels at the edge, before any update of this step lands
   always @(posedge clock) begin : watch_ports
      req_item_type seen_req;
      rsp_item_type seen_rsp;
      if (!reset) begin
         // register writes first so a word in the same edge would see them
         if (csr_valid && csr_ready) sb.write_register(csr_index, csr_data);
         if (req_valid && !req_stall) begin
            seen_req.action              = req_action;
            seen_req.sample_min_mv       = req_sample_min_mv;
            seen_req.sample_max_mv       = req_sample_max_mv;
            seen_req.charge_level_pm     = req_charge_level_pm;
            seen_req.charge_switch_on    = req_charge_switch_on;
            seen_req.discharge_switch_on = req_discharge_switch_on;
            seen_req.is_charging         = req_is_charging;
            seen_req.now_ms              = req_now_ms;
            sb.note_request(seen_req);
         end
         if (rsp_valid && !rsp_stall) begin
            seen_rsp.charge_current_ma    = rsp_charge_current_ma;
            seen_rsp.discharge_current_ma = rsp_discharge_current_ma;
            seen_rsp.full_block           = rsp_full_block;
            seen_rsp.empty_block          = rsp_empty_block;
            seen_rsp.ramp_blocked         = rsp_ramp_blocked;
            seen_rsp.corrected_level_pm   = rsp_corrected_level_pm;
            seen_rsp.recalibrate          = rsp_recalibrate;
            seen_rsp.recalibrate_percent  = rsp_recalibrate_percent;
            seen_rsp.note_code            = rsp_note_code;
            seen_rsp.avg_min_mv           = rsp_avg_min_mv;
            seen_rsp.avg_max_mv           = rsp_avg_max_mv;
            sb.check_response(seen_rsp);
         end
      end
   end

   // offer one word, with idling now and then ahead of it, and hold it until taken
   task automatic send_word(input req_item_type w);
      if (!quiet_stretch && $urandom_range(99, 0) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_action              <= w.action;
      req_sample_min_mv       <= w.sample_min_mv;
      req_sample_max_mv       <= w.sample_max_mv;
      req_charge_level_pm     <= w.charge_level_pm;
      req_charge_switch_on    <= w.charge_switch_on;
      req_discharge_switch_on <= w.discharge_switch_on;
      req_is_charging         <= w.is_charging;
      req_now_ms              <= w.now_ms;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_fields(input logic act, input int unsigned smin, smax, soc,
                              input bit csw, dsw, chg, input bit [TIME_W-1:0] t);
      req_item_type w;
      w.action              = act;
      w.sample_min_mv       = MV_W'(smin);
      w.sample_max_mv       = MV_W'(smax);
      w.charge_level_pm     = SOC_W'(soc);
      w.charge_switch_on    = csw;
      w.discharge_switch_on = dsw;
      w.is_charging         = chg;
      w.now_ms              = t;
      send_word(w);
   endtask

   function automatic req_item_type random_word();
      req_item_type w;
      w.action              = 1'($urandom_range(1, 0));
      w.sample_min_mv       = MV_W'($urandom());
      w.sample_max_mv       = MV_W'($urandom());
      w.charge_level_pm     = SOC_W'($urandom());
      w.charge_switch_on    = 1'($urandom_range(1, 0));
      w.discharge_switch_on = 1'($urandom_range(1, 0));
      w.is_charging         = 1'($urandom_range(1, 0));
      w.now_ms              = $urandom();
      return w;
   endfunction

   // stop offering and wait until every result word has come back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(data);
      do @(posedge clock); while (!csr_ready);
   endtask

   // voltage registers get random upper bits that the block must drop
   function automatic int unsigned with_stray_bits(input int unsigned mv);
      return (mv & 32'h3FFF) | ($urandom_range(15, 0) << MV_W);
   endfunction

   task automatic set_registers(input int unsigned lb, lr, fu, rs, rd, hs, cl, dl);
      write_reg(REG_LOW_CELL_BLOCK, with_stray_bits(lb));
      write_reg(REG_LOW_CELL_RELEASE, with_stray_bits(lr));
      write_reg(REG_CELL_FULL, with_stray_bits(fu));
      write_reg(REG_CHARGE_RESUME, with_stray_bits(rs));
      write_reg(REG_RAMP_DOWN, with_stray_bits(rd));
      write_reg(REG_HARD_STOP, with_stray_bits(hs));
      write_reg(REG_CHARGE_LIMIT, cl);
      write_reg(REG_DISCHARGE_LIMIT, dl);
      csr_valid <= 1'b0;
   endtask

   // episodes of sample triplets followed by a step, each kind aimed at one
   // part of the control rules; some noise and some broken triplets mixed in
   task automatic run_episodes(input int n_words);
      int          sent;
      int          kind;
      int          n_samp;
      int          r;
      int unsigned min_lo, min_hi, max_lo, max_hi, soc_lo, soc_hi, chg_pct;
      sent = 0;
      while (sent < n_words) begin
         kind = $urandom_range(9, 0);
         if (kind == 0) begin
            repeat (4) begin
               send_word(random_word());
               sent++;
            end
         end else begin
            case (kind)
               // ramping up from a low level
               1, 2, 3: begin
                  min_lo = 3000; min_hi = 3300; max_lo = 3100; max_hi = 3345;
                  soc_lo = 100;  soc_hi = 940;  chg_pct = 90;
               end
               // taper caps and full block region
               4, 5: begin
                  min_lo = 3100; min_hi = 3300; max_lo = 3200; max_hi = 3470;
                  soc_lo = 930;  soc_hi = 1010; chg_pct = 85;
               end
               // high cells: ramp down, hold, hard stop
               6, 7: begin
                  min_lo = 3200; min_hi = 3400; max_lo = 3380; max_hi = 3520;
                  soc_lo = 940;  soc_hi = 1012; chg_pct = 85;
               end
               // low cells: discharge block and recalibration to empty
               8: begin
                  min_lo = 2700; min_hi = 3200; max_lo = 2800; max_hi = 3300;
                  soc_lo = 0;    soc_hi = 300;  chg_pct = 30;
               end
               default: begin
                  min_lo = 0; min_hi = 16383; max_lo = 0; max_hi = 16383;
                  soc_lo = 0; soc_hi = 2047;  chg_pct = 50;
               end
            endcase
            repeat ($urandom_range(12, 4)) begin
               n_samp = ($urandom_range(19, 0) == 0) ? $urandom_range(5, 0) : 3;
               repeat (n_samp) begin
                  send_fields(ACT_SAMPLE, $urandom_range(min_hi, min_lo),
                              $urandom_range(max_hi, max_lo), $urandom_range(2047, 0),
                              1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                              1'($urandom_range(1, 0)), clock_ms);
                  sent++;
               end
               // mostly past the ramp period, sometimes inside it, rarely a jump
               r = $urandom_range(99, 0);
               if (r < 3) clock_ms = $urandom();
               else if (r < 28) clock_ms += $urandom_range(10000, 0);
               else clock_ms += $urandom_range(16000, 10001);
               send_fields(ACT_STEP, $urandom_range(16383, 0), $urandom_range(16383, 0),
                           $urandom_range(soc_hi, soc_lo), $urandom_range(99, 0) < 92,
                           $urandom_range(99, 0) < 92, $urandom_range(99, 0) < chg_pct,
                           clock_ms);
               sent++;
            end
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, averaging start-up, then each control rule
      send_fields(ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 0);
      send_fields(ACT_SAMPLE, 16383, 16383, 2047, 1, 1, 1, 32'hFFFF_FFFF);
      send_fields(ACT_SAMPLE, 16383, 16383, 1000, 0, 1, 0, 1);
      // full and hard stop notes together, hard stop wins
      send_fields(ACT_STEP, 0, 16383, 2047, 1, 1, 1, 32'hFFFF_FFFF);
      repeat (3) send_fields(ACT_SAMPLE, 2500, 3300, 500, 1, 1, 1, 0);
      // low cells with discharge switch open, time wrapped past zero
      send_fields(ACT_STEP, 0, 0, 500, 1, 0, 1, 5);
      send_fields(ACT_STEP, 16383, 0, 1500, 1, 1, 1, 20000);
      repeat (3) send_fields(ACT_SAMPLE, 3200, 3380, 0, 0, 0, 0, 0);
      // charge level over full forces recalibration to 100 percent
      send_fields(ACT_STEP, 0, 0, 2047, 1, 1, 1, 40000);
      send_fields(ACT_STEP, 0, 0, 960, 0, 1, 1, 60000);
      repeat (3) send_fields(ACT_SAMPLE, 3100, 3300, 2047, 1, 1, 1, 0);
      // restart current refused with the charge switch open, then taken
      send_fields(ACT_STEP, 0, 0, 500, 0, 1, 1, 80000);
      send_fields(ACT_STEP, 0, 0, 500, 1, 1, 0, 0);

      // reset register values
      clock_ms = $urandom();
      run_episodes(280);
      settle();

      // moderate settings with lower limits
      set_registers(2950, 3150, 3450, 3340, 3410, 3490, 60000, 80000);
      run_episodes(300);
      settle();

      // all thresholds at the top, limits at 200000
      set_registers(16383, 16383, 16383, 16383, 16383, 16383, 200000, 200000);
      run_episodes(150);
      settle();

      // all thresholds and limits at zero
      set_registers(0, 0, 0, 0, 0, 0, 0, 0);
      run_episodes(150);
      settle();

      // long stretch without idling, time about to wrap, room to ramp high
      quiet_stretch = 1'b1;
      clock_ms      = 32'hFFFF_FFFF - 32'd200000;
      set_registers(32'(LOW_CELL_BLOCK_RST), 32'(LOW_CELL_RELEASE_RST), 32'(CELL_FULL_RST),
                    32'(CHARGE_RESUME_RST), 32'(RAMP_DOWN_RST), 32'(HARD_STOP_RST),
                    200000, 1);
      run_episodes(350);
      settle();
      quiet_stretch = 1'b0;

      // limit lowered under the present setting
      set_registers(32'(LOW_CELL_BLOCK_RST), 32'(LOW_CELL_RELEASE_RST), 32'(CELL_FULL_RST),
                    32'(CHARGE_RESUME_RST), 32'(RAMP_DOWN_RST), 32'(HARD_STOP_RST),
                    8000, 50000);
      run_episodes(300);
      settle();

      // scattered thresholds and limits
      set_registers($urandom_range(3600, 2800), $urandom_range(3600, 2800),
                    $urandom_range(3600, 2800), $urandom_range(3600, 2800),
                    $urandom_range(3600, 2800), $urandom_range(3600, 2800),
                    $urandom_range(200000, 0), $urandom_range(200000, 0));
      run_episodes(250);
      settle();

      // let any stray result word show up
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("** battery_charge_current_controller_top: PASSED **");
      end else begin
         $display("** battery_charge_current_controller_top: FAILED **");
      end
      $finish;
   end

endmodule

### battery_charge_current_controller_top.f
design/bccc_pkg.sv
design/battery_charge_current_controller_top.sv
dv/charge_limit_check_pkg.sv
dv/battery_charge_current_controller_top_tb.sv
